[hw/rtl/ntt_pkg.sv]
// ----------------------------------------------------------------------------
// ntt_pkg
// Shared constants, types and modular helpers for the NTT block.
// ----------------------------------------------------------------------------
package ntt_pkg;

  localparam int unsigned MAX_LOG_SIZE_DEF = 10;
  localparam int unsigned VAL_W = 30;
  localparam int unsigned LG_W  = 5;
  localparam int unsigned ROOT_LOG = 23;

  localparam logic [VAL_W-1:0] MOD    = 30'd998244353;
  localparam logic [VAL_W-1:0] MOD_M1 = 30'd998244352;
  localparam logic [VAL_W-1:0] ROOT   = 30'd15311432;
  localparam logic [VAL_W-1:0] IROOT  = 30'd469870224;
  localparam logic [VAL_W-1:0] ONE    = 30'd1;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic REG_INVERSE  = 1'b0;
  localparam logic REG_LOG_SIZE = 1'b1;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic             busy;
    logic [VAL_W-1:0] prod;
  } mul_rsp_t;

  function automatic logic [VAL_W-1:0] mod_add(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MOD}) s = s - {1'b0, MOD};
    return s[VAL_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] mod_sub(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    if (a >= b) s = {1'b0, a} - {1'b0, b};
    else        s = {1'b0, a} + {1'b0, MOD} - {1'b0, b};
    return s[VAL_W-1:0];
  endfunction

endpackage

[hw/rtl/ntt_mulmod.sv]
// ----------------------------------------------------------------------------
// ntt_mulmod
// Bit-serial modular multiplier, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module ntt_mulmod (
  input  logic              clk,
  input  logic              rst_n,
  input  ntt_pkg::mul_req_t req,
  output ntt_pkg::mul_rsp_t rsp
);

  logic [ntt_pkg::VAL_W-1:0] a_r, a_nxt;
  logic [ntt_pkg::VAL_W-1:0] b_r, b_nxt;
  logic [ntt_pkg::VAL_W-1:0] acc_r, acc_nxt;
  logic [ntt_pkg::LG_W-1:0]  cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [ntt_pkg::VAL_W:0]   d1, d2;

  always_comb begin
    d1 = {acc_r, 1'b0};
    if (d1 >= {1'b0, ntt_pkg::MOD}) d1 = d1 - {1'b0, ntt_pkg::MOD};
    d2 = d1;
    if (b_r[ntt_pkg::VAL_W-1]) d2 = d1 + {1'b0, a_r};
    if (d2 >= {1'b0, ntt_pkg::MOD}) d2 = d2 - {1'b0, ntt_pkg::MOD};

    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      acc_nxt = d2[ntt_pkg::VAL_W-1:0];
      b_nxt   = {b_r[ntt_pkg::VAL_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      a_nxt    = req.a;
      b_nxt    = req.b;
      acc_nxt  = '0;
      cnt_nxt  = ntt_pkg::LG_W'(ntt_pkg::VAL_W - 1);
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.busy = busy_r;
  assign rsp.prod = acc_r;

endmodule

[hw/rtl/ntt_transform.sv]
// ----------------------------------------------------------------------------
// ntt_transform
// Radix-2 NTT modulo 998244353 with frame store, sequencer and APB registers.
// ----------------------------------------------------------------------------
// A push is written into the frame store as it is accepted; a pop's result sits
// in an output register. The push that completes a frame of n = 2^L points starts
// the transform, during which in_ready stays low: a bit-reverse pass that
// swaps each mirrored pair, then n/2*L butterflies, all sharing the one
// bit-serial modular multiplier (two products per butterfly), plus (22-s)
// squarings per stage s for the twiddle step, and in inverse mode a scaling
// pass over every point.
module ntt_transform #(
  parameter int unsigned MAX_LOG_SIZE = ntt_pkg::MAX_LOG_SIZE_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_cmd,
  input  logic [ntt_pkg::VAL_W-1:0] in_coeff,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ntt_pkg::VAL_W-1:0] out_value,
  output logic                      out_last,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int unsigned AW    = MAX_LOG_SIZE;
  localparam int unsigned CW    = MAX_LOG_SIZE + 1;
  localparam int unsigned DEPTH = 1 << MAX_LOG_SIZE;

  typedef enum logic [4:0] {
    S_IDLE, S_POP, S_BR_CHK, S_BR_RDJ, S_BR_WRI, S_BR_WRJ,
    S_ST_SET, S_SQ, S_SQ_W, S_BF_RD, S_BF_RDY, S_BF_MUL, S_BF_MW,
    S_BF_WRX, S_BF_WRY, S_BF_WW, S_SC_RD, S_SC_MUL, S_SC_W
  } state_t;

  state_t state_r;

  logic [ntt_pkg::VAL_W-1:0] mem [DEPTH];
  logic [ntt_pkg::VAL_W-1:0] rdata_r;
  logic [AW-1:0]             raddr;
  logic                      we;
  logic [AW-1:0]             waddr;
  logic [ntt_pkg::VAL_W-1:0] wdata;

  logic                      inv_r;
  logic [3:0]                log_size_r;
  logic                      run_inv_r;
  logic [ntt_pkg::LG_W-1:0]  lg_r;
  logic [CW-1:0]             n_r;
  logic [CW-1:0]             load_count_r;
  logic [CW-1:0]             read_pointer_r;
  logic                      frame_ready_r;
  logic [CW-1:0]             i_r;
  logic [CW-1:0]             b_r;
  logic [ntt_pkg::LG_W-1:0]  s_r;
  logic [ntt_pkg::LG_W-1:0]  sq_r;
  logic [ntt_pkg::VAL_W-1:0] wlen_r, w_r, x_r, t_r, a_r;
  logic                      out_valid_r, out_last_r;
  logic [ntt_pkg::VAL_W-1:0] out_value_r;

  ntt_pkg::mul_req_t mreq;
  ntt_pkg::mul_rsp_t mrsp;

  logic [ntt_pkg::LG_W-1:0]  lg_cur;
  logic [CW-1:0]             n_cur;
  logic [ntt_pkg::VAL_W-1:0] coeff_red;
  logic [CW-1:0]             push_addr, push_cnt;
  logic [CW-1:0]             j_idx;
  logic [AW-1:0]             rev;
  logic [CW-1:0]             mask, ax, ay, b_inc;
  logic [ntt_pkg::VAL_W-1:0] ninv;
  logic                      acc_in;
  logic                      cfg_wr;

  ntt_mulmod u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == ntt_pkg::REG_LOG_SIZE) ? {28'd0, log_size_r}
                                                      : {31'd0, inv_r};

  assign lg_cur = ({1'b0, log_size_r} > ntt_pkg::LG_W'(MAX_LOG_SIZE))
                  ? ntt_pkg::LG_W'(MAX_LOG_SIZE) : {1'b0, log_size_r};
  assign n_cur  = CW'(1) << lg_cur;
  assign coeff_red = (in_coeff >= ntt_pkg::MOD) ? in_coeff - ntt_pkg::MOD : in_coeff;
  assign push_addr = frame_ready_r ? '0 : load_count_r;
  assign push_cnt  = push_addr + 1'b1;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign acc_in   = in_valid && in_ready;

  always_comb begin
    for (int k = 0; k < AW; k++) rev[AW-1-k] = i_r[k];
  end
  assign j_idx = CW'(rev >> (ntt_pkg::LG_W'(AW) - lg_r));

  assign mask  = (CW'(1) << s_r) - 1'b1;
  assign ax    = ((b_r >> s_r) << (s_r + 1'b1)) | (b_r & mask);
  assign ay    = ax | (CW'(1) << s_r);
  assign b_inc = b_r + 1'b1;
  assign ninv  = ntt_pkg::MOD - (ntt_pkg::MOD_M1 >> lg_r);

  always_comb begin
    raddr = read_pointer_r[AW-1:0];
    we    = 1'b0;
    waddr = push_addr[AW-1:0];
    wdata = coeff_red;
    mreq  = '0;
    unique case (state_r)
      S_IDLE: begin
        we = acc_in && (in_cmd == ntt_pkg::CMD_PUSH);
      end
      S_BR_CHK: raddr = i_r[AW-1:0];
      S_BR_RDJ: raddr = j_idx[AW-1:0];
      S_BR_WRI: begin
        we    = 1'b1;
        waddr = i_r[AW-1:0];
        wdata = rdata_r;
      end
      S_BR_WRJ: begin
        we    = 1'b1;
        waddr = j_idx[AW-1:0];
        wdata = a_r;
      end
      S_SQ: begin
        mreq.start = (sq_r != '0);
        mreq.a     = wlen_r;
        mreq.b     = wlen_r;
      end
      S_BF_RD:  raddr = ax[AW-1:0];
      S_BF_RDY: raddr = ay[AW-1:0];
      S_BF_MUL: begin
        mreq.start = 1'b1;
        mreq.a     = rdata_r;
        mreq.b     = w_r;
      end
      S_BF_WRX: begin
        we         = 1'b1;
        waddr      = ax[AW-1:0];
        wdata      = ntt_pkg::mod_add(x_r, t_r);
        mreq.start = 1'b1;
        mreq.a     = w_r;
        mreq.b     = wlen_r;
      end
      S_BF_WRY: begin
        we    = 1'b1;
        waddr = ay[AW-1:0];
        wdata = ntt_pkg::mod_sub(x_r, t_r);
      end
      S_SC_RD: raddr = i_r[AW-1:0];
      S_SC_MUL: begin
        mreq.start = 1'b1;
        mreq.a     = rdata_r;
        mreq.b     = ninv;
      end
      S_SC_W: begin
        we    = mrsp.done;
        waddr = i_r[AW-1:0];
        wdata = mrsp.prod;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      inv_r          <= 1'b0;
      log_size_r     <= 4'd10;
      load_count_r   <= '0;
      read_pointer_r <= '0;
      frame_ready_r  <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == ntt_pkg::REG_INVERSE) inv_r <= pwdata[0];
        else                                  log_size_r <= pwdata[3:0];
      end
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (acc_in) begin
            if (in_cmd == ntt_pkg::CMD_PUSH) begin
              frame_ready_r  <= 1'b0;
              read_pointer_r <= '0;
              if (push_cnt >= n_cur) begin
                load_count_r <= '0;
                run_inv_r    <= inv_r;
                lg_r         <= lg_cur;
                n_r          <= n_cur;
                i_r          <= CW'(1);
                state_r      <= S_BR_CHK;
              end else begin
                load_count_r <= push_cnt;
              end
            end else if (frame_ready_r) begin
              n_r     <= n_cur;
              state_r <= S_POP;
            end
          end
        end
        S_POP: begin
          out_valid_r <= 1'b1;
          out_value_r <= rdata_r;
          if (read_pointer_r + 1'b1 >= n_r) begin
            out_last_r     <= 1'b1;
            frame_ready_r  <= 1'b0;
            read_pointer_r <= '0;
          end else begin
            out_last_r     <= 1'b0;
            read_pointer_r <= read_pointer_r + 1'b1;
          end
          state_r <= S_IDLE;
        end
        S_BR_CHK: begin
          if (i_r >= n_r) begin
            s_r     <= '0;
            state_r <= S_ST_SET;
          end else if (i_r < j_idx) begin
            state_r <= S_BR_RDJ;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        S_BR_RDJ: begin
          a_r     <= rdata_r;
          state_r <= S_BR_WRI;
        end
        S_BR_WRI: state_r <= S_BR_WRJ;
        S_BR_WRJ: begin
          i_r     <= i_r + 1'b1;
          state_r <= S_BR_CHK;
        end
        S_ST_SET: begin
          if (s_r == lg_r) begin
            if (run_inv_r) begin
              i_r     <= '0;
              state_r <= S_SC_RD;
            end else begin
              frame_ready_r <= 1'b1;
              state_r       <= S_IDLE;
            end
          end else begin
            wlen_r  <= run_inv_r ? ntt_pkg::IROOT : ntt_pkg::ROOT;
            sq_r    <= ntt_pkg::LG_W'(ntt_pkg::ROOT_LOG - 1) - s_r;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          if (sq_r == '0) begin
            w_r     <= ntt_pkg::ONE;
            b_r     <= '0;
            state_r <= S_BF_RD;
          end else begin
            state_r <= S_SQ_W;
          end
        end
        S_SQ_W: begin
          if (mrsp.done) begin
            wlen_r  <= mrsp.prod;
            sq_r    <= sq_r - 1'b1;
            state_r <= S_SQ;
          end
        end
        S_BF_RD:  state_r <= S_BF_RDY;
        S_BF_RDY: begin
          x_r     <= rdata_r;
          state_r <= S_BF_MUL;
        end
        S_BF_MUL: state_r <= S_BF_MW;
        S_BF_MW: begin
          if (mrsp.done) begin
            t_r     <= mrsp.prod;
            state_r <= S_BF_WRX;
          end
        end
        S_BF_WRX: state_r <= S_BF_WRY;
        S_BF_WRY: state_r <= S_BF_WW;
        S_BF_WW: begin
          if (mrsp.done) begin
            w_r <= ((b_inc & mask) == '0) ? ntt_pkg::ONE : mrsp.prod;
            b_r <= b_inc;
            if (b_inc == (n_r >> 1)) begin
              s_r     <= s_r + 1'b1;
              state_r <= S_ST_SET;
            end else begin
              state_r <= S_BF_RD;
            end
          end
        end
        S_SC_RD:  state_r <= S_SC_MUL;
        S_SC_MUL: state_r <= S_SC_W;
        S_SC_W: begin
          if (mrsp.done) begin
            i_r <= i_r + 1'b1;
            if (i_r + 1'b1 >= n_r) begin
              frame_ready_r <= 1'b1;
              state_r       <= S_IDLE;
            end else begin
              state_r <= S_SC_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule

[hw/rtl/ntt_checker.sv]
// ----------------------------------------------------------------------------
// ntt_checker
// Port-level assertions for the NTT block, bound to the top level.
// ----------------------------------------------------------------------------
module ntt_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_cmd,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [ntt_pkg::VAL_W-1:0] out_value,
  input logic                      out_last,
  input logic                      pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_last))
    else $error("result changed while stalled");

  a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result stalled");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && (in_cmd == ntt_pkg::CMD_POP), 2))
    else $error("result without pop request");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind ntt_transform ntt_checker u_ntt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_cmd    (in_cmd),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_value (out_value),
  .out_last  (out_last),
  .pready    (pready)
);

[bench/ntt_checker.sv]
// ----------------------------------------------------------------------------
// ntt_tb_checker
// Watches the request, result and register channels of ntt_transform, keeps
// its own copy of the frame store and registers, computes the expected
// transform when a frame completes, and compares every returned point.
// ----------------------------------------------------------------------------
module ntt_tb_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic                      in_cmd,
  input  logic [ntt_pkg::VAL_W-1:0] in_coeff,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [ntt_pkg::VAL_W-1:0] out_value,
  input  logic                      out_last,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  input  logic                      pready,
  output int                        errors,
  output int                        outstanding
);

  typedef struct {
    logic [ntt_pkg::VAL_W-1:0] value;
    logic                      last;
  } point_t;

  logic [ntt_pkg::VAL_W-1:0] points [1024];
  int unsigned               load_cnt;
  int unsigned               rd_ptr;
  bit                        frame_rdy;
  bit                        inv_mode;
  logic [3:0]                lg_reg;
  point_t                    pending_points [$];
  point_t                    got;
  point_t                    want;
  int unsigned               eff_lg;
  int unsigned               frame_n;
  logic [ntt_pkg::VAL_W-1:0] c;

  function automatic longint unsigned mmul(longint unsigned a, longint unsigned b);
    return (a * b) % longint'(ntt_pkg::MOD);
  endfunction

  function automatic longint unsigned mpow(longint unsigned b, longint unsigned e);
    longint unsigned r;
    r = 1;
    while (e != 0) begin
      if (e[0]) r = mmul(r, b);
      b = mmul(b, b);
      e = e >> 1;
    end
    return r;
  endfunction

  task automatic transform_frame(int unsigned lg);
    int unsigned               n, j, half;
    longint unsigned           w, wstep, x, y, root;
    logic [ntt_pkg::VAL_W-1:0] t;
    n = 1 << lg;
    for (int unsigned i = 1; i < n; i++) begin
      j = 0;
      for (int unsigned b = 0; b < lg; b++)
        if (i[b]) j |= 1 << (lg - 1 - b);
      if (i < j) begin
        t = points[i];
        points[i] = points[j];
        points[j] = t;
      end
    end
    root = inv_mode ? mpow(ntt_pkg::ROOT, ntt_pkg::MOD - 2) : ntt_pkg::ROOT;
    for (int unsigned s = 0; s < lg; s++) begin
      half = 1 << s;
      wstep = root;
      for (int unsigned q = s + 1; q < ntt_pkg::ROOT_LOG; q++) wstep = mmul(wstep, wstep);
      for (int unsigned st = 0; st < n; st += 2 * half) begin
        w = 1;
        for (int unsigned k = 0; k < half; k++) begin
          x = points[st + k];
          y = mmul(points[st + k + half], w);
          points[st + k] = ntt_pkg::VAL_W'((x + y) % ntt_pkg::MOD);
          points[st + k + half] = ntt_pkg::VAL_W'((x + ntt_pkg::MOD - y) % ntt_pkg::MOD);
          w = mmul(w, wstep);
        end
      end
    end
    if (inv_mode) begin
      w = mpow(n, ntt_pkg::MOD - 2);
      for (int unsigned i = 0; i < n; i++) points[i] = ntt_pkg::VAL_W'(mmul(points[i], w));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      load_cnt = 0;
      rd_ptr = 0;
      frame_rdy = 0;
      inv_mode = 0;
      lg_reg = 4'd10;
      pending_points.delete();
      errors = 0;
    end else begin
      eff_lg = (lg_reg > 10) ? 10 : lg_reg;
      frame_n = 1 << eff_lg;
      if (out_valid && out_ready) begin
        got.value = out_value;
        got.last = out_last;
        if (pending_points.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: value %0d last %0d", got.value, got.last);
        end else begin
          want = pending_points.pop_front();
          if (got.value !== want.value || got.last !== want.last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected value %0d last %0d, got value %0d last %0d",
                       want.value, want.last, got.value, got.last);
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == {ntt_pkg::REG_INVERSE, 2'b00}) inv_mode = pwdata[0];
        else if (paddr == {ntt_pkg::REG_LOG_SIZE, 2'b00}) lg_reg = pwdata[3:0];
      end
      if (in_valid && in_ready) begin
        if (in_cmd == ntt_pkg::CMD_PUSH) begin
          c = (in_coeff >= ntt_pkg::MOD) ? in_coeff - ntt_pkg::MOD : in_coeff;
          if (frame_rdy) begin
            frame_rdy = 0;
            rd_ptr = 0;
            load_cnt = 0;
          end
          if (load_cnt < 1024) points[load_cnt] = c;
          load_cnt++;
          if (load_cnt >= frame_n) begin
            transform_frame(eff_lg);
            load_cnt = 0;
            rd_ptr = 0;
            frame_rdy = 1;
          end
        end else if (frame_rdy) begin
          want.value = points[rd_ptr];
          if (rd_ptr + 1 >= frame_n) begin
            want.last = 1;
            frame_rdy = 0;
            rd_ptr = 0;
          end else begin
            want.last = 0;
            rd_ptr++;
          end
          pending_points.push_back(want);
        end
      end
    end
    outstanding = pending_points.size();
  end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives pushes, pops and register writes into ntt_transform: a directed
// pass over the length extremes, unreduced residues, early pops, abandoned
// frames and length changes, then random frames of random size and direction
// under three idle/stall regimes. The checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic                      in_cmd;
  logic [ntt_pkg::VAL_W-1:0] in_coeff;
  logic                      out_valid;
  logic                      out_ready;
  logic [ntt_pkg::VAL_W-1:0] out_value;
  logic                      out_last;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [2:0]                paddr;
  logic [31:0]               pwdata;
  logic [31:0]               prdata;
  logic                      pready;
  int                        errors;
  int                        outstanding;
  int                        send_idle_pct;
  int                        recv_stall_pct;
  int                        sent;

  ntt_transform uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd), .in_coeff(in_coeff),
    .out_valid(out_valid), .out_ready(out_ready), .out_value(out_value),
    .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ntt_tb_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd), .in_coeff(in_coeff),
    .out_valid(out_valid), .out_ready(out_ready), .out_value(out_value),
    .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .errors(errors), .outstanding(outstanding)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(negedge clk) begin
    if (sent < 217) begin
      send_idle_pct <= 15;
      recv_stall_pct <= 76;
    end else if (sent < 433) begin
      send_idle_pct <= 76;
      recv_stall_pct <= 15;
    end else begin
      send_idle_pct <= 0;
      recv_stall_pct <= 0;
    end
  end

  task automatic send_request(logic cmd, logic [ntt_pkg::VAL_W-1:0] coeff);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_coeff <= coeff;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic push(logic [ntt_pkg::VAL_W-1:0] coeff);
    send_request(ntt_pkg::CMD_PUSH, coeff);
  endtask

  task automatic pop();
    send_request(ntt_pkg::CMD_POP, ntt_pkg::VAL_W'($urandom));
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    while (!in_ready) @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_mode(int unsigned lg, bit inv);
    write_reg({ntt_pkg::REG_LOG_SIZE, 2'b00}, lg);
    write_reg({ntt_pkg::REG_INVERSE, 2'b00}, 32'(inv));
  endtask

  function automatic logic [ntt_pkg::VAL_W-1:0] rand_coeff();
    case ($urandom_range(0, 7))
      0: return ntt_pkg::VAL_W'($urandom);
      1: return $urandom_range(0, 1) ? ntt_pkg::MOD_M1 : '0;
      default: return ntt_pkg::VAL_W'($urandom_range(0, 998244352));
    endcase
  endfunction

  initial begin
    #40000000;
    $display("testbench failed");
    $finish;
  end

  initial begin
    int unsigned lg;
    int unsigned n;
    int unsigned npops;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = ntt_pkg::CMD_PUSH;
    in_coeff = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sent = 0;
    send_idle_pct = 15;
    recv_stall_pct = 76;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    pop();
    set_mode(0, 0);
    push('0);
    pop();
    push(ntt_pkg::MOD_M1);
    push({ntt_pkg::VAL_W{1'b1}});
    pop();
    pop();
    set_mode(2, 1);
    push(ntt_pkg::MOD_M1);
    push(30'd1);
    push(ntt_pkg::MOD);
    push(30'd123456789);
    repeat (4) pop();
    set_mode(3, 0);
    for (int i = 0; i < 8; i++) push(rand_coeff());
    pop();
    pop();
    write_reg({ntt_pkg::REG_LOG_SIZE, 2'b00}, 1);
    pop();
    write_reg({ntt_pkg::REG_LOG_SIZE, 2'b00}, 15);
    push(30'd5);
    push(30'd7);
    write_reg({ntt_pkg::REG_LOG_SIZE, 2'b00}, 10);
    push(30'd9);
    write_reg({ntt_pkg::REG_LOG_SIZE, 2'b00}, 1);
    push(30'd11);
    pop();
    pop();

    while (sent < 650) begin
      lg = ($urandom_range(0, 9) == 0) ? 5 : $urandom_range(0, 4);
      n = 1 << lg;
      set_mode(lg, $urandom_range(0, 1));
      for (int unsigned i = 0; i < n; i++) begin
        if ($urandom_range(0, 19) == 0) pop();
        push(rand_coeff());
      end
      npops = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n) : n;
      for (int unsigned i = 0; i < npops; i++) pop();
      if ($urandom_range(0, 9) == 0) pop();
    end

    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
